/* rtl/lap3_pkg.sv */
// ----------------------------------------------------------------------------
// lap3_pkg
// Shared types and constants of the 3x3 Laplacian stream filter.
// ----------------------------------------------------------------------------
package lap3_pkg;

	localparam int PIX_W   = 8;
	localparam int CFG_DW  = 13;
	localparam int CFG_IW  = 2;
	localparam int VAL_W   = 12;
	localparam int COORD_W = 12;
	localparam int ABS_W   = 11;
	localparam int SUM_W   = 35;

	// register indexes of the configuration port
	localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] REG_ABS_MODE     = 2'd2;

	localparam logic [CFG_DW-1:0] RESET_WIDTH  = 13'd640;
	localparam logic [CFG_DW-1:0] RESET_HEIGHT = 13'd480;

	// item commands
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic                      frame_last;
		logic signed [VAL_W-1:0]   filter_value;
		logic        [COORD_W-1:0] out_row;
		logic        [COORD_W-1:0] out_col;
		logic        [SUM_W-1:0]   frame_abs_sum;
	} result_t;

	// one accepted item as it leaves the sequencer
	typedef struct packed {
		logic               valid;
		logic               drain;
		logic [PIX_W-1:0]   pixel;
		logic               emit_a;    // result for column c-1
		logic               emit_b;    // result for column c (row end)
		logic               first_col; // c == 1, left neighbor clamps
		logic               last;
		logic               up_older;
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
	} ctrl_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    res0;
		result_t    res1;
	} push_t;

endpackage

/* rtl/lap3_if.sv */
// ----------------------------------------------------------------------------
// lap3_if
// Valid/ready stream channels for pixel items and filter results.
// ----------------------------------------------------------------------------
interface lap3_in_if;
	import lap3_pkg::*;

	logic             valid;
	logic             ready;
	logic             cmd;
	logic [PIX_W-1:0] pixel;

	modport source(output valid, cmd, pixel, input ready);
	modport sink(input valid, cmd, pixel, output ready);
endinterface

interface lap3_out_if;
	import lap3_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VAL_W-1:0]   filter_value;
	logic        [COORD_W-1:0] out_row;
	logic        [COORD_W-1:0] out_col;
	logic                      frame_last;
	logic        [SUM_W-1:0]   frame_abs_sum;

	modport source(output valid, filter_value, out_row, out_col, frame_last, frame_abs_sum,
		input ready);
	modport sink(input valid, filter_value, out_row, out_col, frame_last, frame_abs_sum,
		output ready);
endinterface

/* rtl/lap3_ram.sv */
// ----------------------------------------------------------------------------
// lap3_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module lap3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/lap3_seq.sv */
// ----------------------------------------------------------------------------
// lap3_seq
// Configuration registers, row/column/drain counters and line store read issue.
// ----------------------------------------------------------------------------
module lap3_seq #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lap3_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [lap3_pkg::CFG_DW-1:0]    cfg_data,
	input  logic                           accept,
	input  logic                           cmd,
	input  logic [lap3_pkg::PIX_W-1:0]     pixel,
	output logic                           rd_en,
	output logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
	output logic [$clog2(MAX_WIDTH)-1:0]   addr_s1,
	output lap3_pkg::ctrl_t                ctrl_s1,
	output logic                           abs_mode,
	output logic                           restart
);
	import lap3_pkg::*;

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int WCW = $clog2(MAX_WIDTH + 1);
	localparam int HCW = $clog2(MAX_HEIGHT + 1);

	logic [CFG_DW-1:0] image_width_q;
	logic [CFG_DW-1:0] image_height_q;
	logic              abs_mode_q;

	logic [WCW-1:0] col_q;
	logic [WCW-1:0] drain_q;
	logic [HCW-1:0] row_q;

	logic [WCW-1:0] eff_w;
	logic [HCW-1:0] eff_h;
	logic           pix_go;
	logic           drn_go;
	logic [WCW-1:0] cur;
	logic           col_end;
	logic           cfg_hit;
	ctrl_t          ctrl_next;

	always_comb begin
		if (image_width_q < CFG_DW'(2)) begin
			eff_w = WCW'(2);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			eff_w = WCW'(MAX_WIDTH);
		end else begin
			eff_w = WCW'(image_width_q);
		end
		if (image_height_q < CFG_DW'(1)) begin
			eff_h = HCW'(1);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			eff_h = HCW'(MAX_HEIGHT);
		end else begin
			eff_h = HCW'(image_height_q);
		end
	end

	always_comb begin
		case (cfg_index)
			REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_ABS_MODE: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	assign restart = cfg_hit;
	assign abs_mode = abs_mode_q;

	// items out of order are dropped here and never reach the store
	assign pix_go  = accept && !cfg_we && (cmd == CMD_PIXEL) && (row_q < eff_h) && (col_q < eff_w);
	assign drn_go  = accept && !cfg_we && (cmd == CMD_DRAIN) && (row_q >= eff_h)
		&& (drain_q < eff_w);
	assign cur     = pix_go ? col_q : drain_q;
	assign col_end = (cur == eff_w - WCW'(1));
	assign rd_en   = pix_go || drn_go;
	assign rd_addr = cur[AW-1:0];

	always_comb begin
		ctrl_next.valid     = pix_go || drn_go;
		ctrl_next.drain     = drn_go;
		ctrl_next.pixel     = pixel;
		ctrl_next.first_col = (cur == WCW'(1));
		ctrl_next.out_col   = COORD_W'(cur);
		if (pix_go) begin
			ctrl_next.emit_a   = (row_q != '0) && (cur != '0);
			ctrl_next.emit_b   = (row_q != '0) && col_end;
			ctrl_next.last     = 1'b0;
			ctrl_next.up_older = (row_q >= HCW'(2));
			ctrl_next.out_row  = COORD_W'(row_q - HCW'(1));
		end else begin
			ctrl_next.emit_a   = (cur != '0);
			ctrl_next.emit_b   = col_end;
			ctrl_next.last     = col_end;
			ctrl_next.up_older = (eff_h >= HCW'(2));
			ctrl_next.out_row  = COORD_W'(eff_h - HCW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RESET_WIDTH;
			image_height_q <= RESET_HEIGHT;
			abs_mode_q     <= 1'b0;
			col_q          <= '0;
			row_q          <= '0;
			drain_q        <= '0;
			ctrl_s1        <= '0;
		end else begin
			ctrl_s1 <= ctrl_next;
			if (cfg_hit) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
					REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
					REG_ABS_MODE:     abs_mode_q     <= cfg_data[0];
					default: ;
				endcase
				col_q   <= '0;
				row_q   <= '0;
				drain_q <= '0;
			end else if (pix_go) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + HCW'(1);
				end else begin
					col_q <= col_q + WCW'(1);
				end
			end else if (drn_go) begin
				if (col_end) begin
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= '0;
				end else begin
					drain_q <= drain_q + WCW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= rd_addr;
		end
	end

endmodule

/* rtl/lap3_kernel.sv */
// ----------------------------------------------------------------------------
// lap3_kernel
// Line store update, 3x3 column window, kernel arithmetic and frame sum.
// ----------------------------------------------------------------------------
module lap3_kernel (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lap3_pkg::ctrl_t             ctrl_s1,
	input  logic [2*lap3_pkg::PIX_W-1:0] rd_data,
	input  logic                        abs_mode,
	input  logic                        restart,
	output logic                        wr_en,
	output logic [2*lap3_pkg::PIX_W-1:0] wr_data,
	output logic [1:0]                  inflight,
	output lap3_pkg::push_t             push
);
	import lap3_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] mid;
		logic [9:0]       sum;
	} column_t;

	// store word: older row in the upper byte, newer row in the lower byte
	logic [PIX_W-1:0] older;
	logic [PIX_W-1:0] newer;
	logic [PIX_W-1:0] up;
	logic [PIX_W-1:0] dn;
	column_t          col_new;

	column_t win_a_q;
	column_t win_b_q;
	column_t win_c_q;
	ctrl_t   ctrl_s2;

	column_t                 left;
	logic [11:0]             total_a;
	logic [11:0]             total_b;
	logic [11:0]             nine_b;
	logic [11:0]             nine_c;
	logic signed [12:0]      va_wide;
	logic signed [12:0]      vb_wide;
	logic signed [12:0]      aa_wide;
	logic signed [12:0]      ab_wide;

	logic                    valid_s3;
	logic                    emit_a_s3;
	logic                    emit_b_s3;
	logic                    last_s3;
	logic [COORD_W-1:0]      row_s3;
	logic [COORD_W-1:0]      col_s3;
	logic signed [VAL_W-1:0] va_s3;
	logic signed [VAL_W-1:0] vb_s3;
	logic [ABS_W-1:0]        aa_s3;
	logic [ABS_W-1:0]        ab_s3;

	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] acc_next;
	logic [11:0]      add;
	result_t          res_a;
	result_t          res_b;

	// s1: store data is back, write the shifted column and form its sums
	assign older   = rd_data[2*PIX_W-1:PIX_W];
	assign newer   = rd_data[PIX_W-1:0];
	assign up      = ctrl_s1.up_older ? older : newer;
	assign dn      = ctrl_s1.drain ? newer : ctrl_s1.pixel;
	assign wr_en   = ctrl_s1.valid && !ctrl_s1.drain;
	assign wr_data = {newer, ctrl_s1.pixel};

	always_comb begin
		col_new.mid = newer;
		col_new.sum = {2'b00, up} + {2'b00, newer} + {2'b00, dn};
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.valid) begin
			win_c_q <= col_new;
			win_b_q <= win_c_q;
			win_a_q <= win_b_q;
		end
	end

	// s2: 9*center minus the nine-pixel sum equals 8*center minus the ring
	assign left    = ctrl_s2.first_col ? win_b_q : win_a_q;
	assign total_a = {2'b00, left.sum} + {2'b00, win_b_q.sum} + {2'b00, win_c_q.sum};
	assign total_b = {2'b00, win_b_q.sum} + {1'b0, win_c_q.sum, 1'b0};
	assign nine_b  = {1'b0, win_b_q.mid, 3'b000} + {4'b0000, win_b_q.mid};
	assign nine_c  = {1'b0, win_c_q.mid, 3'b000} + {4'b0000, win_c_q.mid};
	assign va_wide = $signed({1'b0, nine_b}) - $signed({1'b0, total_a});
	assign vb_wide = $signed({1'b0, nine_c}) - $signed({1'b0, total_b});
	assign aa_wide = va_wide[12] ? -va_wide : va_wide;
	assign ab_wide = vb_wide[12] ? -vb_wide : vb_wide;

	always_ff @(posedge clk) begin
		row_s3 <= ctrl_s2.out_row;
		col_s3 <= ctrl_s2.out_col;
		va_s3  <= va_wide[VAL_W-1:0];
		vb_s3  <= vb_wide[VAL_W-1:0];
		aa_s3  <= aa_wide[ABS_W-1:0];
		ab_s3  <= ab_wide[ABS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2   <= '0;
			valid_s3  <= 1'b0;
			emit_a_s3 <= 1'b0;
			emit_b_s3 <= 1'b0;
			last_s3   <= 1'b0;
			acc_q     <= '0;
		end else begin
			ctrl_s2   <= ctrl_s1;
			valid_s3  <= ctrl_s2.valid && (ctrl_s2.emit_a || ctrl_s2.emit_b);
			emit_a_s3 <= ctrl_s2.emit_a;
			emit_b_s3 <= ctrl_s2.emit_b;
			last_s3   <= ctrl_s2.last;
			if (restart) begin
				acc_q <= '0;
			end else if (valid_s3) begin
				acc_q <= last_s3 ? '0 : acc_next;
			end
		end
	end

	// s3: accumulate and hand the results to the output queue
	assign add      = (emit_a_s3 ? {1'b0, aa_s3} : 12'd0) + (emit_b_s3 ? {1'b0, ab_s3} : 12'd0);
	assign acc_next = acc_q + SUM_W'(add);

	always_comb begin
		res_a.filter_value  = abs_mode ? $signed({1'b0, aa_s3}) : va_s3;
		res_a.out_row       = row_s3;
		res_a.out_col       = col_s3 - COORD_W'(1);
		res_a.frame_last    = 1'b0;
		res_a.frame_abs_sum = '0;
		res_b.filter_value  = abs_mode ? $signed({1'b0, ab_s3}) : vb_s3;
		res_b.out_row       = row_s3;
		res_b.out_col       = col_s3;
		res_b.frame_last    = last_s3;
		res_b.frame_abs_sum = last_s3 ? acc_next : '0;
		push.res0 = emit_a_s3 ? res_a : res_b;
		push.res1 = res_b;
		push.n    = valid_s3 ? (2'(emit_a_s3) + 2'(emit_b_s3)) : 2'd0;
	end

	assign inflight = 2'(ctrl_s1.valid) + 2'(ctrl_s2.valid) + 2'(valid_s3);

endmodule

/* rtl/lap3_out_fifo.sv */
// ----------------------------------------------------------------------------
// lap3_out_fifo
// Result queue taking up to two items a cycle and giving one a cycle on ready.
// ----------------------------------------------------------------------------
module lap3_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lap3_pkg::push_t               push,
	lap3_out_if.source                    results,
	output logic [lap3_pkg::FIFO_CW-1:0]  count
);
	import lap3_pkg::*;

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wp_q;
	logic [FIFO_AW-1:0]   rp_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;
	result_t              head;

	assign head  = mem_q[rp_q];
	assign pop   = results.valid && results.ready;
	assign count = count_q;

	assign results.valid         = (count_q != '0);
	assign results.filter_value  = head.filter_value;
	assign results.out_row       = head.out_row;
	assign results.out_col       = head.out_col;
	assign results.frame_last    = head.frame_last;
	assign results.frame_abs_sum = head.frame_abs_sum;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.res0;
		end
		if (push.n == 2'd2) begin
			mem_q[wp_q + FIFO_AW'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + FIFO_AW'(push.n);
			count_q <= count_q + FIFO_CW'(push.n) - FIFO_CW'(pop);
			if (pop) begin
				rp_q <= rp_q + FIFO_AW'(1);
			end
		end
	end

endmodule

/* rtl/laplace_3x3_filter_stream_top.sv */
// ----------------------------------------------------------------------------
// laplace_3x3_filter_stream_top
// 3x3 eight-neighbour Laplacian over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the pixels channel in raster order (cmd = pixel); after the
// last row the source sends image_width drain items to flush the bottom row.
// Each result on the results channel carries the filtered value (signed, or
// absolute in abs mode), its row and column, and on the final result of the
// frame the frame's sum of absolute values. Borders replicate edge pixels.
// The window lags the input by one row and one column: the item for (r, c)
// completes the result for (r-1, c-1); the last pixel of a row completes two.
// Results pass s1, s2, s3 and the queue. One item is taken per cycle while
// pixels.ready is high; the line store, one RAM of MAX_WIDTH words holding
// the two previous rows, is read and written once per item in a three-stage
// pipeline, and a 16-entry result queue absorbs the double result at row
// end. When the receiver stalls the queue fills and pixels.ready drops once
// its free space can no longer cover the items in flight. Reset clears
// counters, sum and queue, not the line store. Configuration writes to used
// registers restart the frame; the user must make them only while the block
// is idle; the block does not enforce it. Items out of order give no result.
// ----------------------------------------------------------------------------
module laplace_3x3_filter_stream_top #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lap3_pkg::CFG_IW-1:0] cfg_index,
	input  logic [lap3_pkg::CFG_DW-1:0] cfg_data,
	lap3_in_if.sink                     pixels,
	lap3_out_if.source                  results
);
	import lap3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        addr_s1;
	ctrl_t                ctrl_s1;
	logic                 abs_mode;
	logic                 restart;
	logic                 wr_en;
	logic [2*PIX_W-1:0]   wr_data;
	logic [2*PIX_W-1:0]   rd_data;
	logic [1:0]           inflight;
	push_t                push;
	logic [FIFO_CW-1:0]   count;

	// every item in flight may still add two results to the queue
	assign pixels.ready = (7'(count) + {4'b0000, inflight, 1'b0} + 7'd2) <= 7'(FIFO_DEPTH);

	lap3_seq #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (pixels.valid && pixels.ready),
		.cmd      (pixels.cmd),
		.pixel    (pixels.pixel),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.addr_s1  (addr_s1),
		.ctrl_s1  (ctrl_s1),
		.abs_mode (abs_mode),
		.restart  (restart)
	);

	lap3_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	lap3_kernel u_kernel (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_s1 (ctrl_s1),
		.rd_data (rd_data),
		.abs_mode(abs_mode),
		.restart (restart),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.inflight(inflight),
		.push    (push)
	);

	lap3_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.results(results),
		.count  (count)
	);

	// queue credit must never let a push overrun the storage
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(5'(count) + 5'(push.n)) <= 5'(FIFO_DEPTH) + 5'(results.valid && results.ready))
		else $error("result queue overflow");

	// only the final result of a frame carries the sum
	a_sum_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.frame_last |-> results.frame_abs_sum == '0)
		else $error("frame sum on a result that is not last");

	// an item arriving with a configuration write is dropped
	a_cfg_drops_item: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !ctrl_s1.valid)
		else $error("item entered pipeline during configuration write");

endmodule

/* bench/tb_laplace_3x3_filter_stream_top.sv */
// ----------------------------------------------------------------------------
// tb_laplace_3x3_filter_stream_top
// Self-checking bench for the 3x3 Laplacian stream filter.
// ----------------------------------------------------------------------------
// A scoreboard class mirrors the line stores, counters and running sum and
// predicts every result from the accepted items. It is checked field by field
// against the results channel, in order.
// Directed frames cover the extreme filter values, abs mode and out-of-order
// items. A sweep covers saturated sizes, a mid-frame restart and the unused
// register index. A long receiver stall backs the block up. Random frames
// follow, with noise items, truncated frames and random idling on both sides.
// ----------------------------------------------------------------------------
module tb_laplace_3x3_filter_stream_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lap3_pkg::*;

	localparam int MAX_W        = 4096;
	localparam int MAX_H        = 4096;
	localparam int SETTLE_SLACK = 16;      // leave margin after the pipeline
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 700;
	localparam int NOISE_PCT    = 5;

	localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;

	class lap_scoreboard;
		typedef enum {OLDER_ROW, NEWER_ROW, CUR_ROW} row_sel_e;

		int         width_reg;
		int         height_reg;
		bit         abs_on;
		logic [7:0] older_row[MAX_W];
		logic [7:0] newer_row[MAX_W];
		logic [7:0] cur_row[MAX_W];
		int         row_cnt;
		int         col_cnt;
		int         drain_cnt;
		logic [SUM_W-1:0] abs_sum;
		result_t    expected_results[$];
		int         errors;

		function new();
			width_reg = RESET_WIDTH;
			height_reg = RESET_HEIGHT;
			abs_on = 1'b0;
			errors = 0;
			foreach (older_row[i]) begin
				older_row[i] = '0;
				newer_row[i] = '0;
				cur_row[i] = '0;
			end
			restart();
		endfunction

		function void restart();
			row_cnt = 0;
			col_cnt = 0;
			drain_cnt = 0;
			abs_sum = '0;
		endfunction

		function int eff_width();
			if (width_reg < 2) return 2;
			if (width_reg > MAX_W) return MAX_W;
			return width_reg;
		endfunction

		function int eff_height();
			if (height_reg < 1) return 1;
			if (height_reg > MAX_H) return MAX_H;
			return height_reg;
		endfunction

		function void apply_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
			case (idx)
				REG_IMAGE_WIDTH: width_reg = val;
				REG_IMAGE_HEIGHT: height_reg = val;
				REG_ABS_MODE: abs_on = val[0];
				default: return;
			endcase
			restart();
		endfunction

		function int pix(row_sel_e sel, int c);
			case (sel)
				OLDER_ROW: return int'(older_row[c]);
				NEWER_ROW: return int'(newer_row[c]);
				default: return int'(cur_row[c]);
			endcase
		endfunction

		function void predict_result(row_sel_e up, row_sel_e dn, int row, int col, int w,
			bit last);
			int l;
			int r;
			int ring;
			int v;
			int a;
			result_t res;
			l = (col > 0) ? col - 1 : col;
			r = (col + 1 < w) ? col + 1 : col;
			ring = pix(up, l) + pix(up, col) + pix(up, r)
				+ pix(NEWER_ROW, l) + pix(NEWER_ROW, r)
				+ pix(dn, l) + pix(dn, col) + pix(dn, r);
			v = 8 * pix(NEWER_ROW, col) - ring;
			a = (v < 0) ? -v : v;
			abs_sum = abs_sum + SUM_W'(a);
			res.filter_value = VAL_W'(abs_on ? a : v);
			res.out_row = COORD_W'(row);
			res.out_col = COORD_W'(col);
			res.frame_last = last;
			res.frame_abs_sum = last ? abs_sum : '0;
			expected_results.push_back(res);
		endfunction

		// one accepted item: advance the frame and queue the results it completes
		function void take_item(logic cmd, logic [PIX_W-1:0] pixel);
			int w;
			int h;
			int c;
			int d;
			row_sel_e up;
			w = eff_width();
			h = eff_height();
			if (cmd == CMD_PIXEL) begin
				if (row_cnt >= h || col_cnt >= w) return;
				c = col_cnt;
				cur_row[c] = pixel;
				if (row_cnt >= 1) begin
					up = (row_cnt >= 2) ? OLDER_ROW : NEWER_ROW;
					if (c >= 1) predict_result(up, CUR_ROW, row_cnt - 1, c - 1, w, 1'b0);
					if (c == w - 1) predict_result(up, CUR_ROW, row_cnt - 1, c, w, 1'b0);
				end
				col_cnt = c + 1;
				if (col_cnt >= w) begin
					col_cnt = 0;
					for (int i = 0; i < w; i++) begin
						older_row[i] = newer_row[i];
						newer_row[i] = cur_row[i];
					end
					row_cnt++;
				end
			end else begin
				if (row_cnt < h || drain_cnt >= w) return;
				d = drain_cnt;
				// bottom border: the last row stands in for the row below
				up = (h >= 2) ? OLDER_ROW : NEWER_ROW;
				if (d >= 1) predict_result(up, NEWER_ROW, h - 1, d - 1, w, 1'b0);
				if (d == w - 1) predict_result(up, NEWER_ROW, h - 1, d, w, 1'b1);
				drain_cnt = d + 1;
				if (drain_cnt >= w) restart();
			end
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (expected_results.size() == 0) begin
				$error("unexpected result: row %0d col %0d value %0d",
					got.out_row, got.out_col, got.filter_value);
				errors++;
				return;
			end
			exp = expected_results.pop_front();
			if (got.filter_value !== exp.filter_value) begin
				$error("filter_value: expected %0d, got %0d", exp.filter_value,
					got.filter_value);
				errors++;
			end
			if (got.out_row !== exp.out_row) begin
				$error("out_row: expected %0d, got %0d", exp.out_row, got.out_row);
				errors++;
			end
			if (got.out_col !== exp.out_col) begin
				$error("out_col: expected %0d, got %0d", exp.out_col, got.out_col);
				errors++;
			end
			if (got.frame_last !== exp.frame_last) begin
				$error("frame_last: expected %0d, got %0d", exp.frame_last,
					got.frame_last);
				errors++;
			end
			if (got.frame_abs_sum !== exp.frame_abs_sum) begin
				$error("frame_abs_sum: expected %0d, got %0d", exp.frame_abs_sum,
					got.frame_abs_sum);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	lap3_in_if  pix_if();
	lap3_out_if res_if();

	laplace_3x3_filter_stream_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pix_if),
		.results  (res_if)
	);

	lap_scoreboard sb = new();

	int          tx_gap_max;
	int          rx_gap_max;
	bit          hold_results;
	int          well_formed;
	int unsigned cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// result receiver
	initial begin
		int gap;
		result_t got;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				hold_results = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = $urandom_range(rx_gap_max, 0);
			if (gap > 0) begin
				res_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (res_if.valid !== 1'b1);
			got.filter_value = res_if.filter_value;
			got.out_row = res_if.out_row;
			got.out_col = res_if.out_col;
			got.frame_last = res_if.frame_last;
			got.frame_abs_sum = res_if.frame_abs_sum;
			sb.check_result(got);
		end
	end

	// valid stays high into the next item when no gap is drawn
	task automatic send_item(logic cmd, logic [PIX_W-1:0] pixel);
		int gap;
		gap = $urandom_range(tx_gap_max, 0);
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.cmd <= cmd;
		pix_if.pixel <= pixel;
		do @(posedge clk); while (pix_if.ready !== 1'b1);
		sb.take_item(cmd, pixel);
	endtask

	task automatic settle();
		pix_if.valid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.apply_reg(idx, val);
	endtask

	task automatic set_frame(int w, int h, bit abs_mode);
		settle();
		write_reg(REG_IMAGE_WIDTH, CFG_DW'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_DW'(h));
		write_reg(REG_ABS_MODE, CFG_DW'(abs_mode));
	endtask

	// random frame of w x h (effective sizes); drains follow only a full frame
	task automatic send_frame(int w, int h, int noise_pct, int keep);
		for (int i = 0; i < keep; i++) begin
			if ($urandom_range(99, 0) < noise_pct) send_item(CMD_DRAIN, PIX_W'($urandom));
			send_item(CMD_PIXEL, PIX_W'($urandom_range(255, 0)));
			well_formed++;
		end
		if (keep == w * h) begin
			for (int d = 0; d < w; d++) begin
				if ($urandom_range(99, 0) < noise_pct)
					send_item(CMD_PIXEL, PIX_W'($urandom));
				send_item(CMD_DRAIN, PIX_W'($urandom));
				well_formed++;
			end
		end
	endtask

	initial begin
		int w;
		int h;
		int keep;
		bit need_cfg;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		pix_if.valid <= 1'b0;
		pix_if.cmd <= CMD_PIXEL;
		pix_if.pixel <= '0;
		tx_gap_max = 0;
		rx_gap_max = 0;
		hold_results = 1'b0;
		well_formed = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single bright pixel on black: +2040 at the center; stray items ignored
		set_frame(3, 3, 1'b0);
		send_item(CMD_DRAIN, 8'h00);
		for (int i = 0; i < 9; i++) send_item(CMD_PIXEL, (i == 4) ? 8'hFF : 8'h00);
		send_item(CMD_PIXEL, 8'hFF);
		for (int d = 0; d < 3; d++) send_item(CMD_DRAIN, 8'hFF);
		// dark pixel on white in abs mode: -2040 shown as 2040
		set_frame(3, 3, 1'b1);
		for (int i = 0; i < 9; i++) send_item(CMD_PIXEL, (i == 4) ? 8'h00 : 8'hFF);
		for (int d = 0; d < 3; d++) send_item(CMD_DRAIN, 8'h00);
		// signed mode, same picture
		set_frame(3, 3, 1'b0);
		for (int i = 0; i < 9; i++) send_item(CMD_PIXEL, (i == 4) ? 8'h00 : 8'hFF);
		for (int d = 0; d < 3; d++) send_item(CMD_DRAIN, 8'h00);

		// unused index mid-frame leaves the frame alone
		tx_gap_max = 13;
		rx_gap_max = 13;
		set_frame(5, 4, 1'b0);
		for (int i = 0; i < 7; i++) send_item(CMD_PIXEL, PIX_W'($urandom));
		settle();
		write_reg(REG_UNUSED, 13'h1FFF);
		for (int i = 7; i < 20; i++) send_item(CMD_PIXEL, PIX_W'($urandom));
		for (int d = 0; d < 5; d++) send_item(CMD_DRAIN, 8'h00);
		// a real write mid-frame restarts it
		for (int i = 0; i < 6; i++) send_item(CMD_PIXEL, PIX_W'($urandom));
		settle();
		write_reg(REG_ABS_MODE, 13'd1);
		send_frame(5, 4, 0, 20);

		// saturated sizes, back to back
		tx_gap_max = 0;
		rx_gap_max = 0;
		set_frame(0, 0, 1'b0);
		send_frame(2, 1, 0, 2);
		set_frame(1, 1, 1'b1);
		send_frame(2, 1, 0, 2);

		// long receiver stall while the sender keeps going
		rx_gap_max = 13;
		set_frame(16, 8, 1'b1);
		hold_results = 1'b1;
		send_frame(16, 8, 0, 16 * 8);

		well_formed = 0;
		need_cfg = 1'b1;
		w = 2;
		h = 1;
		while (well_formed < RANDOM_ITEMS) begin
			tx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 13;
			rx_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 13;
			if (need_cfg || $urandom_range(2, 0) != 0) begin
				w = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 2) : $urandom_range(12, 2);
				h = $urandom_range(6, 1);
				set_frame(w, h, 1'($urandom_range(1, 0)));
			end
			keep = ($urandom_range(14, 0) == 0) ? $urandom_range(w * h - 1, 0) : w * h;
			send_frame(w, h, NOISE_PCT, keep);
			need_cfg = (keep != w * h);
		end

		settle();
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
